// ----- rtl/ffpa_pkg.sv -----
// Shared definitions for the first-fit page allocator: status and opcode codes,
// datapath action codes and the command and status structs between controller and datapath.
// Depends on nothing.
package ffpa_pkg;

   localparam int MAX_EXTENTS_DEF     = 64;
   localparam int PAGE_INDEX_BITS_DEF = 20;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_ADD   = 2'd2;
   localparam logic [1:0] OP_BAD   = 2'd3;

   localparam logic [3:0] A_NONE     = 4'd0;
   localparam logic [3:0] A_LOAD     = 4'd1;
   localparam logic [3:0] A_READ     = 4'd2;
   localparam logic [3:0] A_STEP     = 4'd3;
   localparam logic [3:0] A_ALLOC_WR = 4'd4;
   localparam logic [3:0] A_MRG_BOTH = 4'd5;
   localparam logic [3:0] A_MRG_PREV = 4'd6;
   localparam logic [3:0] A_MRG_NEXT = 4'd7;
   localparam logic [3:0] A_UP_INIT  = 4'd8;
   localparam logic [3:0] A_UP_RD    = 4'd9;
   localparam logic [3:0] A_UP_WR    = 4'd10;
   localparam logic [3:0] A_INS_WR   = 4'd11;
   localparam logic [3:0] A_RM_INIT  = 4'd12;
   localparam logic [3:0] A_DN_RD    = 4'd13;
   localparam logic [3:0] A_DN_WR    = 4'd14;
   localparam logic [3:0] A_RM_DONE  = 4'd15;

   typedef struct packed {
      logic [3:0] act;
      logic       set_status;
      logic [1:0] status;
      logic       page_set;
      logic       tot_add;
      logic       tot_sub;
   } ffpa_cmd_type;

   typedef struct packed {
      logic op_bad;
      logic is_alloc;
      logic zero_count;
      logic scan_end;
      logic fit;
      logic exact;
      logic past;
      logic with_prev;
      logic with_next;
      logic full;
      logic up_done;
      logic dn_done;
   } ffpa_stat_type;

endpackage

// ----- rtl/ffpa_datapath.sv -----
// Datapath of the first-fit page allocator: extent memory, request registers, counters
// and the free total. Depends on ffpa_pkg for the command and status structs.
module ffpa_datapath #(
   parameter int MAX_EXTENTS     = ffpa_pkg::MAX_EXTENTS_DEF,
   parameter int PAGE_INDEX_BITS = ffpa_pkg::PAGE_INDEX_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ffpa_pkg::ffpa_cmd_type       cmd,
   output ffpa_pkg::ffpa_stat_type      stat,
   input  logic [1:0]                   req_opcode,
   input  logic [PAGE_INDEX_BITS-1:0]   req_base_page,
   input  logic [PAGE_INDEX_BITS:0]     req_page_count,
   output logic [1:0]                   rsp_status,
   output logic [PAGE_INDEX_BITS-1:0]   rsp_result_page,
   output logic [PAGE_INDEX_BITS:0]     rsp_free_total
);
   import ffpa_pkg::*;

   localparam int PW = PAGE_INDEX_BITS;
   localparam int AW = $clog2(MAX_EXTENTS);
   localparam int IW = $clog2(MAX_EXTENTS + 1);
   localparam logic [IW-1:0] MAX_CNT = IW'(MAX_EXTENTS);

   logic [PW+PW:0] mem [MAX_EXTENTS];

   logic [1:0]    op_ff;
   logic [PW-1:0] base_ff;
   logic [PW:0]   count_ff;
   logic [IW-1:0] idx_ff, j_ff, used_ff;
   logic [PW:0]   total_ff;
   logic [PW-1:0] prev_start_ff;
   logic [PW:0]   prev_len_ff;
   logic [PW-1:0] rd_start_ff;
   logic [PW:0]   rd_len_ff;
   logic [1:0]    status_ff;
   logic [PW-1:0] page_ff;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [PW-1:0] wr_start;
   logic [PW:0]   wr_len;
   logic [PW:0]   room, count_in;
   logic [PW+1:0] prev_end, tot_sum;
   logic [IW-1:0] idx_m1, j_m1, j_p1;

   assign idx_m1 = idx_ff - IW'(1);
   assign j_m1   = j_ff - IW'(1);
   assign j_p1   = j_ff + IW'(1);

   // Pages left from the base to the end of the page space.
   assign room     = {1'b1, {PW{1'b0}}} - {1'b0, req_base_page};
   assign count_in = (req_opcode != OP_ALLOC && req_page_count > room) ? room : req_page_count;
   assign prev_end = {1'b0, prev_len_ff} + {2'b00, prev_start_ff};
   assign tot_sum  = {1'b0, total_ff} + {1'b0, count_ff};

   always_comb begin
      stat.op_bad     = (op_ff == OP_BAD);
      stat.is_alloc   = (op_ff == OP_ALLOC);
      stat.zero_count = (count_ff == '0);
      stat.scan_end   = (idx_ff == used_ff);
      stat.fit        = (rd_len_ff >= count_ff);
      stat.exact      = (rd_len_ff == count_ff);
      stat.past       = (rd_start_ff > base_ff);
      stat.with_prev  = (op_ff == OP_FREE) && (idx_ff != '0) && (prev_end == {2'b00, base_ff});
      stat.with_next  = (op_ff == OP_FREE) && (idx_ff != used_ff) &&
                        (({1'b0, base_ff} + count_ff) == {1'b0, rd_start_ff});
      stat.full       = (used_ff == MAX_CNT);
      stat.up_done    = (j_ff == idx_ff);
      stat.dn_done    = (j_p1 >= used_ff);
   end

   always_comb begin
      rd_en    = 1'b0;
      rd_addr  = idx_ff[AW-1:0];
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_start = rd_start_ff;
      wr_len   = rd_len_ff;
      case (cmd.act)
         A_READ: begin
            rd_en = 1'b1;
         end
         A_UP_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_m1[AW-1:0];
         end
         A_DN_RD: begin
            rd_en   = 1'b1;
            rd_addr = j_p1[AW-1:0];
         end
         A_ALLOC_WR: begin
            wr_en    = 1'b1;
            wr_start = rd_start_ff + count_ff[PW-1:0];
            wr_len   = rd_len_ff - count_ff;
         end
         A_MRG_BOTH: begin
            wr_en    = 1'b1;
            wr_addr  = idx_m1[AW-1:0];
            wr_start = prev_start_ff;
            wr_len   = prev_len_ff + count_ff + rd_len_ff;
         end
         A_MRG_PREV: begin
            wr_en    = 1'b1;
            wr_addr  = idx_m1[AW-1:0];
            wr_start = prev_start_ff;
            wr_len   = prev_len_ff + count_ff;
         end
         A_MRG_NEXT: begin
            wr_en    = 1'b1;
            wr_start = base_ff;
            wr_len   = rd_len_ff + count_ff;
         end
         A_UP_WR, A_DN_WR: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
         end
         A_INS_WR: begin
            wr_en    = 1'b1;
            wr_start = base_ff;
            wr_len   = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_start, wr_len};
      end
      if (rd_en) begin
         {rd_start_ff, rd_len_ff} <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act == A_LOAD) begin
         op_ff    <= req_opcode;
         base_ff  <= req_base_page;
         count_ff <= count_in;
         page_ff  <= '0;
      end else if (cmd.page_set) begin
         page_ff <= rd_start_ff;
      end
      if (cmd.act == A_STEP) begin
         prev_start_ff <= rd_start_ff;
         prev_len_ff   <= rd_len_ff;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         j_ff     <= '0;
         used_ff  <= '0;
         total_ff <= '0;
      end else begin
         case (cmd.act)
            A_LOAD:     idx_ff <= '0;
            A_STEP:     idx_ff <= idx_ff + IW'(1);
            A_UP_INIT:  j_ff <= used_ff;
            A_UP_WR:    j_ff <= j_m1;
            A_INS_WR:   used_ff <= used_ff + IW'(1);
            A_MRG_BOTH, A_RM_INIT: j_ff <= idx_ff;
            A_DN_WR:    j_ff <= j_p1;
            A_RM_DONE:  used_ff <= used_ff - IW'(1);
            default: begin
            end
         endcase
         if (cmd.tot_add) begin
            total_ff <= tot_sum[PW+1] ? {(PW+1){1'b1}} : tot_sum[PW:0];
         end else if (cmd.tot_sub) begin
            total_ff <= (total_ff > count_ff) ? total_ff - count_ff : '0;
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_result_page = page_ff;
   assign rsp_free_total  = total_ff;

endmodule

// ----- rtl/ffpa_controller.sv -----
// Controller state machine of the first-fit page allocator: sequences scans, shifts and
// writes in the datapath. Depends on ffpa_pkg for the command and status structs.
module ffpa_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_strobe,
   output ffpa_pkg::ffpa_cmd_type  cmd,
   input  ffpa_pkg::ffpa_stat_type stat
);
   import ffpa_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_EXAM   = 4'd3;
   localparam logic [3:0] S_PLACE  = 4'd4;
   localparam logic [3:0] S_UP     = 4'd5;
   localparam logic [3:0] S_UPW    = 4'd6;
   localparam logic [3:0] S_REMOVE = 4'd7;
   localparam logic [3:0] S_DNW    = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.act        = A_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.act  = A_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op_bad) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_MISS;
               state_in       = S_RESP;
            end else if (stat.zero_count) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_ZERO;
               state_in       = S_RESP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               if (stat.is_alloc) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_MISS;
                  state_in       = S_RESP;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               cmd.act  = A_READ;
               state_in = S_EXAM;
            end
         end
         S_EXAM: begin
            if (stat.is_alloc) begin
               if (stat.fit) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_OK;
                  cmd.page_set   = 1'b1;
                  cmd.tot_sub    = 1'b1;
                  if (stat.exact) begin
                     cmd.act  = A_RM_INIT;
                     state_in = S_REMOVE;
                  end else begin
                     cmd.act  = A_ALLOC_WR;
                     state_in = S_RESP;
                  end
               end else begin
                  cmd.act  = A_STEP;
                  state_in = S_SCAN;
               end
            end else if (stat.past) begin
               state_in = S_PLACE;
            end else begin
               cmd.act  = A_STEP;
               state_in = S_SCAN;
            end
         end
         S_PLACE: begin
            cmd.status = ST_OK;
            if (stat.with_prev && stat.with_next) begin
               cmd.act        = A_MRG_BOTH;
               cmd.set_status = 1'b1;
               cmd.tot_add    = 1'b1;
               state_in       = S_REMOVE;
            end else if (stat.with_prev) begin
               cmd.act        = A_MRG_PREV;
               cmd.set_status = 1'b1;
               cmd.tot_add    = 1'b1;
               state_in       = S_RESP;
            end else if (stat.with_next) begin
               cmd.act        = A_MRG_NEXT;
               cmd.set_status = 1'b1;
               cmd.tot_add    = 1'b1;
               state_in       = S_RESP;
            end else if (stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.act  = A_UP_INIT;
               state_in = S_UP;
            end
         end
         S_UP: begin
            if (stat.up_done) begin
               cmd.act        = A_INS_WR;
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
               cmd.tot_add    = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.act  = A_UP_RD;
               state_in = S_UPW;
            end
         end
         S_UPW: begin
            cmd.act  = A_UP_WR;
            state_in = S_UP;
         end
         S_REMOVE: begin
            if (stat.dn_done) begin
               cmd.act  = A_RM_DONE;
               state_in = S_RESP;
            end else begin
               cmd.act  = A_DN_RD;
               state_in = S_DNW;
            end
         end
         S_DNW: begin
            cmd.act  = A_DN_WR;
            state_in = S_REMOVE;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

// ----- rtl/first_fit_page_allocator.sv -----
// Top level of the first-fit page allocator: joins the controller and the datapath.
// Depends on ffpa_pkg, ffpa_controller and ffpa_datapath.
//
// The block keeps a table of free page extents sorted by start page and a running
// total of free pages. A request transfer takes place at a rising edge where start is
// high and busy is low; req_opcode selects allocate, free with merging or add region.
// Exactly one result transfer follows per request: rsp_strobe is high for a single
// cycle with rsp_status, rsp_result_page and rsp_free_total, and the receiver must
// take it then, as it cannot stall the block.
// Busy stays high from the cycle after the request until the result cycle; the next
// request may be transferred in the cycle after the strobe.
// Latency depends on the table: each entry scanned takes a registered memory read,
// then a compare, and each entry moved when an extent is inserted or removed takes
// a read, then a write, on the extent memory, whose one read port and one write
// port are never used together. A zero count or a bad opcode is answered without
// a scan; otherwise the scan and the shift that follows it together pass over the
// table no more than once.
// Synchronous reset empties the table and clears the free total; the extent memory
// itself is not cleared, since only entries below the fill count are ever read.
module first_fit_page_allocator #(
   parameter int MAX_EXTENTS     = ffpa_pkg::MAX_EXTENTS_DEF,
   parameter int PAGE_INDEX_BITS = ffpa_pkg::PAGE_INDEX_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic [PAGE_INDEX_BITS-1:0]   req_base_page,
   input  logic [PAGE_INDEX_BITS:0]     req_page_count,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [PAGE_INDEX_BITS-1:0]   rsp_result_page,
   output logic [PAGE_INDEX_BITS:0]     rsp_free_total
);
   import ffpa_pkg::*;

   // Commands flow from the controller into the datapath, status flags flow back.
   ffpa_cmd_type  cmd;
   ffpa_stat_type stat;

   ffpa_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   ffpa_datapath #(
      .MAX_EXTENTS     (MAX_EXTENTS),
      .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_base_page   (req_base_page),
      .req_page_count  (req_page_count),
      .rsp_status      (rsp_status),
      .rsp_result_page (rsp_result_page),
      .rsp_free_total  (rsp_free_total)
   );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the first-fit page allocator: a queue-fed driver,
// a monitor that predicts each request's result and compares it on the strobe.
// Depends on ffpa_pkg and the first_fit_page_allocator RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ffpa_pkg::*;

   localparam int NEXT      = 64;
   localparam int PBITS     = 20;
   localparam longint PSPACE   = 64'd1 << PBITS;
   localparam longint TOTALMAX = (64'd1 << (PBITS + 1)) - 1;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [1:0]       opcode;
      logic [PBITS-1:0] base;
      logic [PBITS:0]   count;
      int               gap;
   } request_type;

   typedef struct {
      logic [1:0]       status;
      logic [PBITS-1:0] page;
      logic [PBITS:0]   total;
   } answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_opcode = OP_ALLOC;
   logic [PBITS-1:0] req_base_page = '0;
   logic [PBITS:0]   req_page_count = '0;
   logic             rsp_strobe;
   logic [1:0]       rsp_status;
   logic [PBITS-1:0] rsp_result_page;
   logic [PBITS:0]   rsp_free_total;

   request_type pending_requests[$];
   answer_type  awaited_answers[$];
   logic     req_fire = 1'b0;
   int       gap_left = 0;
   int       mismatches = 0;
   int       requests_sent = 0;
   int       answers_seen = 0;
   int       cycles = 0;
   int       full_seen = 0, miss_seen = 0, merge_like = 0;

   // Shadow copy of the extent table, kept in ascending start order.
   longint   ext_start[NEXT];
   longint   ext_len[NEXT];
   int       ext_cnt = 0;
   longint   pool_total = 0;

   first_fit_page_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_base_page(req_base_page),
      .req_page_count(req_page_count), .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status), .rsp_result_page(rsp_result_page),
      .rsp_free_total(rsp_free_total)
   );

   always #6 clock = ~clock;

   // Removes entry pos, closing the gap from above.
   function automatic void drop_extent(int pos);
      for (int i = pos; i + 1 < ext_cnt; i++) begin
         ext_start[i] = ext_start[i + 1];
         ext_len[i] = ext_len[i + 1];
      end
      ext_cnt--;
   endfunction

   // Works out the answer to one request and updates the shadow table.
   function automatic answer_type allocator_answer(request_type r);
      answer_type a;
      longint  cnt, base, page;
      int      pos;
      bit      prev_touch, next_touch;
      a.status = ST_OK;
      page = 0;
      cnt = r.count;
      base = r.base;
      if (r.opcode == OP_BAD) begin
         a.status = ST_MISS;
      end else if (cnt == 0) begin
         a.status = ST_ZERO;
      end else if (r.opcode == OP_ALLOC) begin
         a.status = ST_MISS;
         for (int i = 0; i < ext_cnt; i++) begin
            if (ext_len[i] >= cnt) begin
               page = ext_start[i];
               ext_start[i] += cnt;
               ext_len[i] -= cnt;
               if (ext_len[i] == 0) drop_extent(i);
               pool_total = (pool_total > cnt) ? pool_total - cnt : 0;
               a.status = ST_OK;
               break;
            end
         end
      end else begin
         if (cnt > PSPACE - base) cnt = PSPACE - base;
         pos = 0;
         while (pos < ext_cnt && ext_start[pos] <= base) pos++;
         prev_touch = 1'b0;
         next_touch = 1'b0;
         if (r.opcode == OP_FREE) begin
            prev_touch = pos > 0 && ext_start[pos - 1] + ext_len[pos - 1] == base;
            next_touch = pos < ext_cnt && base + cnt == ext_start[pos];
         end
         if (prev_touch && next_touch) begin
            ext_len[pos - 1] += cnt + ext_len[pos];
            drop_extent(pos);
         end else if (prev_touch) begin
            ext_len[pos - 1] += cnt;
         end else if (next_touch) begin
            ext_start[pos] = base;
            ext_len[pos] += cnt;
         end else if (ext_cnt >= NEXT) begin
            a.status = ST_FULL;
         end else begin
            for (int i = ext_cnt; i > pos; i--) begin
               ext_start[i] = ext_start[i - 1];
               ext_len[i] = ext_len[i - 1];
            end
            ext_start[pos] = base;
            ext_len[pos] = cnt;
            ext_cnt++;
         end
         if (prev_touch || next_touch) merge_like++;
         if (a.status == ST_OK) begin
            pool_total += cnt;
            if (pool_total > TOTALMAX) pool_total = TOTALMAX;
         end
      end
      a.page = (a.status == ST_OK) ? page[PBITS-1:0] : '0;
      a.total = pool_total[PBITS:0];
      return a;
   endfunction

   function automatic void queue_request(logic [1:0] op, longint base, longint cnt, int gap);
      request_type r;
      r.opcode = op;
      r.base = base[PBITS-1:0];
      r.count = cnt[PBITS:0];
      r.gap = gap;
      pending_requests.push_back(r);
   endfunction

   // Driver: inputs move on the falling edge. A request stays up until the
   // monitor has seen its transfer, then the next one follows after its gap.
   always @(negedge clock) begin
      request_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fire) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_opcode <= r.opcode;
            req_base_page <= r.base;
            req_page_count <= r.count;
            gap_left <= r.gap;
            start <= 1'b1;
            requests_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: on each rising edge it notes a request transfer, predicting its
   // answer, and checks any result transfer against the oldest prediction.
   always @(posedge clock) begin
      answer_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("FAILED: results differ");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= start && !busy;
         if (start && !busy) begin
            awaited_answers.push_back(allocator_answer('{req_opcode, req_base_page,
                                                        req_page_count, 0}));
         end
         if (rsp_strobe) begin
            answers_seen++;
            if (rsp_status == ST_FULL) full_seen++;
            if (rsp_status == ST_MISS) miss_seen++;
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result transfer at cycle %0d.", cycles);
            end else begin
               e = awaited_answers.pop_front();
               if (rsp_status !== e.status || rsp_result_page !== e.page ||
                   rsp_free_total !== e.total) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch at cycle %0d: status %0d/%0d page %0h/%0h total %0h/%0h",
                              cycles, e.status, rsp_status, e.page, rsp_result_page,
                              e.total, rsp_free_total);
               end
            end
         end
      end
   end

   initial begin
      int  gap_mode, op_pick, burst_left;
      longint b, c;
      // Directed part: zero counts, the unused opcode, a miss on an empty table,
      // clipping at the top of the page space, merges and exact-size allocation.
      queue_request(OP_ALLOC, 0, 0, 0);
      queue_request(OP_FREE, 5, 0, 1);
      queue_request(OP_ADD, 7, 0, 0);
      queue_request(OP_BAD, 20'hFFFFF, 21'h1FFFFF, 2);
      queue_request(OP_ALLOC, 0, 1, 0);
      queue_request(OP_ADD, 20'hFFFFF, 21'h100000, 3);
      queue_request(OP_ADD, 100, 10, 0);
      queue_request(OP_FREE, 120, 10, 0);
      queue_request(OP_FREE, 110, 10, 16);
      queue_request(OP_FREE, 90, 10, 0);
      queue_request(OP_FREE, 130, 5, 0);
      queue_request(OP_ALLOC, 0, 45, 0);
      queue_request(OP_ALLOC, 0, 1, 0);
      queue_request(OP_ALLOC, 0, 21'h1FFFFF, 0);
      queue_request(OP_ADD, 0, 21'h100000, 5);
      queue_request(OP_ADD, 0, 21'h100000, 0);
      queue_request(OP_FREE, 20'hAAAAA, 21'h155555, 0);
      queue_request(OP_ALLOC, 0, 21'h100000, 0);
      queue_request(OP_ALLOC, 0, 21'h0FFFFF, 0);
      queue_request(OP_ALLOC, 0, 21'h1FFFFF, 0);
      // Random part: runs of scattered adds fill the table, while small frees
      // and allocations near the bottom of the page space merge and split extents.
      burst_left = 0;
      gap_mode = 0;
      for (int n = 0; n < 1500; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(20, 120);
            gap_mode = $urandom_range(0, 2);
         end
         burst_left--;
         op_pick = $urandom_range(0, 99);
         if (op_pick < 35) begin
            c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                             : $urandom_range(1, 64);
            queue_request(OP_ALLOC, $urandom_range(0, 20'hFFFFF), c, 0);
         end else if (op_pick < 70) begin
            b = $urandom_range(0, 2047);
            c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                             : $urandom_range(1, 32);
            queue_request(OP_FREE, b, c, 0);
         end else if (op_pick < 90) begin
            b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                            : 4 * $urandom_range(0, 4095);
            c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                            : $urandom_range(1, 3);
            queue_request(($urandom_range(0, 1) == 0) ? OP_ADD : OP_FREE, b, c, 0);
         end else if (op_pick < 96) begin
            queue_request(2'($urandom_range(0, 2)), $urandom_range(0, 20'hFFFFF), 0, 0);
         end else begin
            queue_request(OP_BAD, $urandom_range(0, 20'hFFFFF),
                          $urandom_range(0, 21'h1FFFFF), 0);
         end
         if (gap_mode == 1)
            pending_requests[$].gap = $urandom_range(0, 16);
         else if (gap_mode == 2)
            pending_requests[$].gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_requests.size() == 0 && !start && awaited_answers.size() == 0);
      repeat (300) @(posedge clock);
      if (awaited_answers.size() != 0) mismatches += awaited_answers.size();

      $display("Ran %0d requests and checked %0d results in %0d cycles.",
               requests_sent, answers_seen, cycles);
      $display("Saw %0d table-full and %0d miss statuses, %0d merging inserts.",
               full_seen, miss_seen, merge_like);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
